// ===== src/csvp_pkg.sv =====
// Shared types, constants and helpers for the delimited text cell parser.
package csvp_pkg;

   localparam int LEN_W = 7;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   localparam int FLAG_STRIP  = 0;
   localparam int FLAG_DQUOTE = 1;
   localparam int FLAG_HEADER = 2;
   localparam int FLAG_ERROR  = 3;

   typedef enum logic [2:0] {
      CSR_SEP,
      CSR_QUOTE,
      CSR_ESC,
      CSR_COMMENT,
      CSR_FLAGS,
      CSR_SKIP
   } csr_idx_type;

   // one entry of the front-to-back queue: a finished cell or a bad-record event
   typedef struct packed {
      logic             bad;
      logic             err;
      logic [LEN_W-1:0] lo;
      logic [LEN_W-1:0] hi;
      logic             rend;
      logic             hdr;
      logic             trunc;
      logic [7:0]       cell_num;
      logic [15:0]      row_num;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SP) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

// ===== src/delimited_text_cell_parser.sv =====
// Top level of the delimited text cell parser.
// Takes one byte a cycle while a cell is being collected. When a cell or row
// ends (or end of input follows a line end), the front hands a command to the
// back through a two-entry queue and holds req_stall high until the back has
// finished with it, since the next cell reuses the cell store. The back reads
// the store through a registered RAM port: IDLE takes the command, then each
// byte passes FETCH (read) and SHOW (output register, held by rsp_stall); an
// empty cell or bad-record event goes from IDLE to SHOW as one beat. Cells
// longer than CELL_BYTES lose the excess bytes and are flagged truncated. After
// a fatal bad record, bytes are still taken but produce nothing until reset.
module delimited_text_cell_parser #(
   parameter int CELL_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_cell_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_cell,
   output logic [7:0]  rsp_cell_number,
   output logic        rsp_row_end,
   output logic        rsp_header_row,
   output logic [15:0] rsp_row_number,
   output logic        rsp_cell_truncated,
   output logic        rsp_bad_record,
   output logic        rsp_parse_error
);
   import csvp_pkg::*;

   localparam int ADDR_W = (CELL_BYTES > 1) ? $clog2(CELL_BYTES) : 1;

   logic             push, pop, back_busy, wr_en;
   cmd_type          cmd_push, cmd_pop;
   queue_status_type q_stat;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]       wr_data, rd_data;

   csvp_front #(.CELL_BYTES(CELL_BYTES), .ADDR_W(ADDR_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .busy        (!q_stat.empty || back_busy),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .push        (push),
      .cmd         (cmd_push),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   csvp_ram #(.WIDTH(8), .DEPTH(CELL_BYTES), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   csvp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .cmd_in  (cmd_push),
      .pop     (pop),
      .cmd_out (cmd_pop),
      .status  (q_stat)
   );

   csvp_back #(.CELL_BYTES(CELL_BYTES), .ADDR_W(ADDR_W)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (!q_stat.empty),
      .q_cmd              (cmd_pop),
      .q_pop              (pop),
      .rd_addr            (rd_addr),
      .rd_data            (rd_data),
      .busy               (back_busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cell_byte      (rsp_cell_byte),
      .rsp_byte_valid     (rsp_byte_valid),
      .rsp_last_of_cell   (rsp_last_of_cell),
      .rsp_cell_number    (rsp_cell_number),
      .rsp_row_end        (rsp_row_end),
      .rsp_header_row     (rsp_header_row),
      .rsp_row_number     (rsp_row_number),
      .rsp_cell_truncated (rsp_cell_truncated),
      .rsp_bad_record     (rsp_bad_record),
      .rsp_parse_error    (rsp_parse_error)
   );

   // the store is never rewritten while a cell is still queued or being read
   a_push_when_empty: assert property (@(posedge clock) disable iff (reset)
      push |-> (q_stat.empty && !back_busy))
      else $error("command pushed while back end busy");

   a_store_quiet: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (q_stat.empty && !back_busy))
      else $error("cell store written during emission");

   a_bad_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_record) |-> (!rsp_byte_valid && !rsp_last_of_cell))
      else $error("bad-record beat carries cell data");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_byte_valid && !rsp_bad_record) |-> rsp_last_of_cell)
      else $error("empty cell beat not marked last");

   a_err_bad: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parse_error) |-> rsp_bad_record)
      else $error("parse error without bad record");

endmodule

// ===== src/csvp_ram.sv =====
// Generic single-port-write, registered-read RAM.
module csvp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/csvp_front.sv =====
// Parser front: configuration registers, byte classification, cell store writes.
module csvp_front #(
   parameter int CELL_BYTES = 64,
   parameter int ADDR_W     = (CELL_BYTES > 1) ? $clog2(CELL_BYTES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   input  logic                 req_valid,
   input  logic                 busy,
   output logic                 req_stall,
   input  logic [7:0]           req_in_byte,
   output logic                 push,
   output csvp_pkg::cmd_type    cmd,
   output logic                 wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [7:0]           wr_data
);
   import csvp_pkg::*;

   typedef enum logic [3:0] {
      PARSE_START, ROW_START, EOL, ESC_EOL, CELL_START,
      IN_CELL, ESC_CELL, QUOTED, ESC_QUOTED, QUOTE_QUOTED
   } pstate_type;

   logic [7:0]  sep_ff, quote_ff, esc_ff, comment_byte_ff;
   logic [3:0]  flags_ff;
   logic [15:0] skip_cfg_ff;

   pstate_type       st_ff, st_in;
   logic [LEN_W-1:0] len_ff, len_in, first_ff, first_in, last_ff, last_in;
   logic             have_ff, have_in, ovf_ff, ovf_in;
   logic [7:0]       pos_ff, pos_in;
   logic [15:0]      rows_ff, rows_in, skip_ff, skip_in;
   logic             comment_ff, comment_in, has_ff, has_in, stopped_ff, stopped_in;

   logic             accept;
   logic [7:0]       c;
   logic             eol, nul, q_hit, e_hit;
   pstate_type       st;
   logic             go_rs, go_cs, go_ic, do_add, do_emit, emit_rend, do_finish, do_bad;
   logic [7:0]       add_val;
   logic             suppress;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign c         = req_in_byte;
   assign eol       = (c == CH_LF) || (c == CH_CR);
   assign nul       = (c == 8'd0);
   assign q_hit     = (quote_ff != 8'd0) && (c == quote_ff);
   assign e_hit     = (esc_ff != 8'd0) && (c == esc_ff);

   always_comb begin
      st_in      = st_ff;
      len_in     = len_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      have_in    = have_ff;
      ovf_in     = ovf_ff;
      pos_in     = pos_ff;
      rows_in    = rows_ff;
      skip_in    = skip_ff;
      comment_in = comment_ff;
      has_in     = has_ff;
      stopped_in = stopped_ff;
      go_rs      = 1'b0;
      go_cs      = 1'b0;
      go_ic      = 1'b0;
      do_add     = 1'b0;
      add_val    = c;
      do_emit    = 1'b0;
      emit_rend  = 1'b0;
      do_finish  = 1'b0;
      do_bad     = 1'b0;
      st         = st_ff;
      wr_en      = 1'b0;
      wr_addr    = len_ff[ADDR_W-1:0];
      push       = 1'b0;
      cmd        = '0;

      if (st_ff == PARSE_START) begin
         rows_in = 16'd1;
         skip_in = skip_cfg_ff;
         st      = ROW_START;
         st_in   = ROW_START;
      end

      case (st)
         ROW_START: go_rs = 1'b1;
         EOL: begin
            if (eol) begin
            end else if (!nul) begin
               st_in = ROW_START;
               go_rs = 1'b1;
            end else begin
               do_bad = 1'b1;
            end
         end
         CELL_START: go_cs = 1'b1;
         ESC_CELL: begin
            do_add  = 1'b1;
            add_val = nul ? CH_LF : c;
            st_in   = eol ? ESC_EOL : IN_CELL;
         end
         ESC_EOL: go_ic = !nul;
         IN_CELL: go_ic = 1'b1;
         QUOTED: begin
            if (nul) begin
            end else if (e_hit) begin
               st_in = ESC_QUOTED;
            end else if (q_hit) begin
               st_in = flags_ff[FLAG_DQUOTE] ? QUOTE_QUOTED : IN_CELL;
            end else begin
               do_add = 1'b1;
            end
         end
         ESC_QUOTED: begin
            do_add  = 1'b1;
            add_val = nul ? CH_LF : c;
            st_in   = QUOTED;
         end
         QUOTE_QUOTED: begin
            if (q_hit) begin
               do_add = 1'b1;
               st_in  = QUOTED;
            end else if (c == sep_ff) begin
               st_in   = CELL_START;
               do_emit = 1'b1;
            end else if (eol || nul) begin
               do_finish = 1'b1;
            end else begin
               do_add = 1'b1;
               st_in  = IN_CELL;
            end
         end
         default: st_in = ROW_START;
      endcase

      if (go_rs) begin
         if (nul) begin
         end else if (eol) begin
            st_in = EOL;
         end else begin
            if (!has_in) begin
               has_in     = 1'b1;
               comment_in = (comment_byte_ff != 8'd0) && (c == comment_byte_ff);
            end
            st_in = CELL_START;
            go_cs = 1'b1;
         end
      end

      if (go_cs) begin
         if (eol || nul) begin
            do_finish = 1'b1;
         end else if (q_hit) begin
            st_in = QUOTED;
         end else if (e_hit) begin
            st_in = ESC_CELL;
         end else if (((c == CH_SP) || (c == CH_TAB)) && flags_ff[FLAG_STRIP]) begin
         end else if (c == sep_ff) begin
            do_emit = 1'b1;
         end else begin
            do_add = 1'b1;
            st_in  = IN_CELL;
         end
      end

      if (go_ic) begin
         if (eol || nul) begin
            do_finish = 1'b1;
         end else if (e_hit) begin
            st_in = ESC_CELL;
         end else if (c == sep_ff) begin
            st_in   = CELL_START;
            do_emit = 1'b1;
         end else begin
            do_add = 1'b1;
         end
      end

      if (do_finish) begin
         do_emit   = 1'b1;
         emit_rend = 1'b1;
      end

      // stripped bounds come from running first/last non-space marks
      suppress = (skip_in != 16'd0) || comment_in;

      if (do_add) begin
         if (len_ff < LEN_W'(CELL_BYTES)) begin
            wr_en  = accept && !stopped_ff;
            len_in = len_ff + LEN_W'(1);
            if (!is_space(add_val)) begin
               if (!have_ff) begin
                  first_in = len_ff;
               end
               have_in = 1'b1;
               last_in = len_ff + LEN_W'(1);
            end
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (do_emit) begin
         cmd.rend     = emit_rend;
         cmd.hdr      = (rows_in == 16'd1) && flags_ff[FLAG_HEADER];
         cmd.trunc    = ovf_ff;
         cmd.cell_num = pos_ff;
         cmd.row_num  = rows_in;
         if (flags_ff[FLAG_STRIP]) begin
            cmd.lo = have_ff ? first_ff : '0;
            cmd.hi = have_ff ? last_ff : '0;
         end else begin
            cmd.lo = '0;
            cmd.hi = len_ff;
         end
         push     = !suppress;
         pos_in   = (pos_ff == 8'hFF) ? pos_ff : pos_ff + 8'd1;
         len_in   = '0;
         ovf_in   = 1'b0;
         have_in  = 1'b0;
      end

      if (do_finish) begin
         if (skip_in != 16'd0) begin
            skip_in = skip_in - 16'd1;
         end else if (!comment_in && (rows_in != 16'hFFFF)) begin
            rows_in = rows_in + 16'd1;
         end
         pos_in     = '0;
         comment_in = 1'b0;
         has_in     = 1'b0;
         st_in      = nul ? ROW_START : EOL;
      end

      if (do_bad) begin
         cmd         = '0;
         cmd.bad     = 1'b1;
         cmd.err     = flags_ff[FLAG_ERROR];
         cmd.row_num = rows_in;
         push        = 1'b1;
         stopped_in  = flags_ff[FLAG_ERROR];
      end

      push    = push && accept && !stopped_ff;
      wr_data = add_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff          <= 8'd44;
         quote_ff        <= 8'd34;
         esc_ff          <= 8'd0;
         comment_byte_ff <= 8'd0;
         flags_ff        <= 4'd2;
         skip_cfg_ff     <= 16'd0;
         st_ff           <= PARSE_START;
         len_ff          <= '0;
         first_ff        <= '0;
         last_ff         <= '0;
         have_ff         <= 1'b0;
         ovf_ff          <= 1'b0;
         pos_ff          <= '0;
         rows_ff         <= 16'd1;
         skip_ff         <= '0;
         comment_ff      <= 1'b0;
         has_ff          <= 1'b0;
         stopped_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SEP:     sep_ff          <= csr_wdata[7:0];
               CSR_QUOTE:   quote_ff        <= csr_wdata[7:0];
               CSR_ESC:     esc_ff          <= csr_wdata[7:0];
               CSR_COMMENT: comment_byte_ff <= csr_wdata[7:0];
               CSR_FLAGS:   flags_ff        <= csr_wdata[3:0];
               CSR_SKIP:    skip_cfg_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && !stopped_ff) begin
            st_ff      <= st_in;
            len_ff     <= len_in;
            first_ff   <= first_in;
            last_ff    <= last_in;
            have_ff    <= have_in;
            ovf_ff     <= ovf_in;
            pos_ff     <= pos_in;
            rows_ff    <= rows_in;
            skip_ff    <= skip_in;
            comment_ff <= comment_in;
            has_ff     <= has_in;
            stopped_ff <= stopped_in;
         end
      end
   end

endmodule

// ===== src/csvp_queue.sv =====
// Two-entry queue carrying cell and event commands from front to back.
module csvp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  csvp_pkg::cmd_type         cmd_in,
   input  logic                      pop,
   output csvp_pkg::cmd_type         cmd_out,
   output csvp_pkg::queue_status_type status
);
   import csvp_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push && (count_ff != 2'd2)) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push && (count_ff != 2'd2)) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && (count_ff != 2'd0)) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push && (count_ff != 2'd2), pop && (count_ff != 2'd0)})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   assign cmd_out      = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);

endmodule

// ===== src/csvp_back.sv =====
// Emitter back: walks the cell store and drives the result register.
module csvp_back #(
   parameter int CELL_BYTES = 64,
   parameter int ADDR_W     = (CELL_BYTES > 1) ? $clog2(CELL_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  csvp_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_cell_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last_of_cell,
   output logic [7:0]        rsp_cell_number,
   output logic              rsp_row_end,
   output logic              rsp_header_row,
   output logic [15:0]       rsp_row_number,
   output logic              rsp_cell_truncated,
   output logic              rsp_bad_record,
   output logic              rsp_parse_error
);
   import csvp_pkg::*;

   typedef enum logic [1:0] {IDLE, FETCH, SHOW} bstate_type;

   bstate_type       st_ff;
   cmd_type          cmd_ff;
   logic [LEN_W-1:0] cur_ff, cur_in;
   logic             fin_ff, valid_ff;
   logic [7:0]       byte_ff, cnum_ff;
   logic             bv_ff, last_ff, rend_ff, hdr_ff, trunc_ff, bad_ff, err_ff;
   logic [15:0]      rnum_ff;

   always_comb begin
      q_pop  = (st_ff == IDLE) && q_valid;
      cur_in = cur_ff;
      if (q_pop) begin
         cur_in = q_cmd.lo;
      end else if ((st_ff == SHOW) && !rsp_stall && !fin_ff) begin
         cur_in = cur_ff + LEN_W'(1);
      end
   end

   // read address runs one step ahead so data is there in FETCH
   assign rd_addr = cur_in[ADDR_W-1:0];
   assign busy    = (st_ff != IDLE);

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (reset) begin
         st_ff    <= IDLE;
         valid_ff <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         case (st_ff)
            IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_cmd;
                  cnum_ff  <= q_cmd.cell_num;
                  rend_ff  <= q_cmd.rend;
                  hdr_ff   <= q_cmd.hdr;
                  rnum_ff  <= q_cmd.row_num;
                  trunc_ff <= q_cmd.trunc;
                  bad_ff   <= q_cmd.bad;
                  err_ff   <= q_cmd.err;
                  if (q_cmd.bad || (q_cmd.lo == q_cmd.hi)) begin
                     byte_ff  <= 8'd0;
                     bv_ff    <= 1'b0;
                     last_ff  <= !q_cmd.bad;
                     fin_ff   <= 1'b1;
                     valid_ff <= 1'b1;
                     st_ff    <= SHOW;
                  end else begin
                     st_ff <= FETCH;
                  end
               end
            end
            FETCH: begin
               byte_ff  <= rd_data;
               bv_ff    <= 1'b1;
               last_ff  <= (cur_ff + LEN_W'(1)) == cmd_ff.hi;
               fin_ff   <= (cur_ff + LEN_W'(1)) == cmd_ff.hi;
               valid_ff <= 1'b1;
               st_ff    <= SHOW;
            end
            SHOW: begin
               if (!rsp_stall) begin
                  valid_ff <= 1'b0;
                  st_ff    <= fin_ff ? IDLE : FETCH;
               end
            end
            default: st_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_cell_byte      = byte_ff;
   assign rsp_byte_valid     = bv_ff;
   assign rsp_last_of_cell   = last_ff;
   assign rsp_cell_number    = cnum_ff;
   assign rsp_row_end        = rend_ff;
   assign rsp_header_row     = hdr_ff;
   assign rsp_row_number     = rnum_ff;
   assign rsp_cell_truncated = trunc_ff;
   assign rsp_bad_record     = bad_ff;
   assign rsp_parse_error    = err_ff;

endmodule

// ===== dv/tb_delimited_text_cell_parser.sv =====
// Self-checking testbench for the delimited text cell parser.
`timescale 1ns / 100ps

module tb_delimited_text_cell_parser;
   import csvp_pkg::*;

   localparam logic [2:0] CSR_UNUSED = 3'd6;
   localparam int         STORE_BYTES = 64;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_CYCLES = 400;

   typedef enum logic [3:0] {
      P_START, P_ROW, P_EOL, P_ESC_EOL, P_CELL, P_IN_CELL, P_ESC_CELL,
      P_QUOTED, P_ESC_QUOTED, P_QUOTE_QUOTED
   } pstate_type;

   typedef struct packed {
      logic [7:0]  cbyte;
      logic        bvalid;
      logic        last;
      logic [7:0]  cnum;
      logic        rend;
      logic        hdr;
      logic [15:0] rnum;
      logic        trunc;
      logic        bad;
      logic        err;
   } beat_type;

   class cell_scoreboard;
      logic [7:0]  sep, quo, esc, cmt;
      logic [3:0]  flags;
      logic [15:0] skip_cfg;
      pstate_type  st;
      logic [7:0]  store[STORE_BYTES];
      int          len;
      bit          ovf;
      logic [7:0]  pos;
      logic [15:0] rows, skip_left, bad_cnt;
      bit          comment_row, row_seen, stopped;
      beat_type    pending[$];
      int          errors;

      function new();
         sep = 8'd44; quo = 8'd34; esc = 0; cmt = 0; flags = 4'd2; skip_cfg = 0;
         st = P_START; len = 0; ovf = 0; pos = 0; rows = 1; skip_left = 0;
         bad_cnt = 0; comment_row = 0; row_seen = 0; stopped = 0; errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_SEP:     sep = v[7:0];
            CSR_QUOTE:   quo = v[7:0];
            CSR_ESC:     esc = v[7:0];
            CSR_COMMENT: cmt = v[7:0];
            CSR_FLAGS:   flags = v[3:0];
            CSR_SKIP:    skip_cfg = v;
            default: ;
         endcase
      endfunction

      function bit blank(logic [7:0] c);
         return c == CH_SP || (c >= 8'h09 && c <= 8'h0D);
      endfunction

      function bit line_end(logic [7:0] c);
         return c == CH_LF || c == CH_CR;
      endfunction

      function void add(logic [7:0] c);
         if (len < STORE_BYTES) begin
            store[len] = c;
            len++;
         end else
            ovf = 1;
      endfunction

      function void put(logic [7:0] b, bit v, bit l, bit re, bit h, bit t, bit bd, bit e);
         beat_type x;
         x = '{cbyte: b, bvalid: v, last: l, cnum: pos, rend: re, hdr: h, rnum: rows,
               trunc: t, bad: bd, err: e};
         pending.push_back(x);
      endfunction

      function void emit_cell(bit re);
         int lo, hi;
         bit h;
         if (skip_left == 0 && !comment_row) begin
            lo = 0;
            hi = len;
            h = (rows == 1) && flags[FLAG_HEADER];
            if (flags[FLAG_STRIP]) begin
               while (lo < hi && blank(store[lo])) lo++;
               while (hi > lo && blank(store[hi-1])) hi--;
            end
            if (hi == lo)
               put(0, 0, 1, re, h, ovf, 0, 0);
            else
               for (int i = lo; i < hi; i++) put(store[i], 1, i + 1 == hi, re, h, ovf, 0, 0);
         end
         if (pos != 8'hFF) pos++;
         len = 0;
         ovf = 0;
      endfunction

      function void finish_row(logic [7:0] c);
         emit_cell(1);
         if (skip_left != 0)
            skip_left--;
         else if (!comment_row && rows != 16'hFFFF)
            rows++;
         pos = 0;
         comment_row = 0;
         row_seen = 0;
         st = (c != 0) ? P_EOL : P_ROW;
      endfunction

      function void cell_start(logic [7:0] c);
         if (line_end(c) || c == 0)
            finish_row(c);
         else if (quo != 0 && c == quo)
            st = P_QUOTED;
         else if (esc != 0 && c == esc)
            st = P_ESC_CELL;
         else if ((c == CH_SP || c == CH_TAB) && flags[FLAG_STRIP])
            ;
         else if (c == sep)
            emit_cell(0);
         else begin
            add(c);
            st = P_IN_CELL;
         end
      endfunction

      function void in_cell(logic [7:0] c);
         if (line_end(c) || c == 0)
            finish_row(c);
         else if (esc != 0 && c == esc)
            st = P_ESC_CELL;
         else if (c == sep) begin
            st = P_CELL;
            emit_cell(0);
         end else
            add(c);
      endfunction

      function void row_start(logic [7:0] c);
         if (c == 0) return;
         if (line_end(c)) begin
            st = P_EOL;
            return;
         end
         if (!row_seen) begin
            row_seen = 1;
            comment_row = (cmt != 0) && (c == cmt);
         end
         st = P_CELL;
         cell_start(c);
      endfunction

      // one accepted input beat
      function void note_byte(logic [7:0] c);
         if (stopped) return;
         if (st == P_START) begin
            rows = 1;
            skip_left = skip_cfg;
            bad_cnt = 0;
            st = P_ROW;
         end
         case (st)
            P_ROW:  row_start(c);
            P_EOL: begin
               if (line_end(c))
                  ;
               else if (c != 0) begin
                  st = P_ROW;
                  row_start(c);
               end else begin
                  if (bad_cnt != 16'hFFFF) bad_cnt++;
                  put(0, 0, 0, 0, 0, 0, 1, flags[FLAG_ERROR]);
                  if (flags[FLAG_ERROR]) stopped = 1;
               end
            end
            P_CELL: cell_start(c);
            P_ESC_CELL: begin
               if (line_end(c)) begin
                  add(c);
                  st = P_ESC_EOL;
               end else begin
                  add(c != 0 ? c : CH_LF);
                  st = P_IN_CELL;
               end
            end
            P_ESC_EOL: if (c != 0) in_cell(c);
            P_IN_CELL: in_cell(c);
            P_QUOTED: begin
               if (c == 0)
                  ;
               else if (esc != 0 && c == esc)
                  st = P_ESC_QUOTED;
               else if (quo != 0 && c == quo)
                  st = flags[FLAG_DQUOTE] ? P_QUOTE_QUOTED : P_IN_CELL;
               else
                  add(c);
            end
            P_ESC_QUOTED: begin
               add(c != 0 ? c : CH_LF);
               st = P_QUOTED;
            end
            P_QUOTE_QUOTED: begin
               if (quo != 0 && c == quo) begin
                  add(c);
                  st = P_QUOTED;
               end else if (c == sep) begin
                  st = P_CELL;
                  emit_cell(0);
               end else if (line_end(c) || c == 0)
                  finish_row(c);
               else begin
                  add(c);
                  st = P_IN_CELL;
               end
            end
            default: st = P_ROW;
         endcase
      endfunction

      function void check_beat(beat_type got);
         beat_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            $display("%0t: beat mismatch, expected %p, actual %p", $time, exp, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid, req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid, rsp_stall;
   logic [7:0]  rsp_cell_byte, rsp_cell_number;
   logic        rsp_byte_valid, rsp_last_of_cell, rsp_row_end, rsp_header_row;
   logic [15:0] rsp_row_number;
   logic        rsp_cell_truncated, rsp_bad_record, rsp_parse_error;

   cell_scoreboard sb;
   logic [7:0]     stream[$];
   int             cycles;
   int             stall_mode;

   delimited_text_cell_parser dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      csr_we = 0; csr_index = 0; csr_wdata = 0;
      req_valid = 0; req_in_byte = 0;
      sb = new();
   end

   // receiver back-pressure, pattern switches every so often
   always @(posedge clock) begin
      cycles <= reset ? 0 : cycles + 1;
      if (cycles % 150 == 0) stall_mode <= $urandom_range(0, 3);
      if (reset)
         rsp_stall <= 1'b0;
      else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= cycles[2];
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_beat('{cbyte: rsp_cell_byte, bvalid: rsp_byte_valid,
                         last: rsp_last_of_cell, cnum: rsp_cell_number,
                         rend: rsp_row_end, hdr: rsp_header_row,
                         rnum: rsp_row_number, trunc: rsp_cell_truncated,
                         bad: rsp_bad_record, err: rsp_parse_error});
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic send_beat(logic [7:0] b);
      req_valid <= 1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
   endtask

   // bursts of random length with random gaps
   task automatic drive_stream();
      int burst;
      while (stream.size() > 0) begin
         burst = $urandom_range(1, 30);
         for (int i = 0; i < burst && stream.size() > 0; i++) send_beat(stream.pop_front());
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_valid <= 0;
   endtask

   task automatic settle();
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h21, 8'h7E));
      while (c == sb.sep || c == sb.quo || c == sb.esc || c == sb.cmt);
      return c;
   endfunction

   function automatic void push_plain(int n);
      repeat (n) stream.push_back(plain_char());
   endfunction

   // one well-formed row built from the current special bytes
   function automatic void push_row();
      int ncell;
      if (sb.cmt != 0 && $urandom_range(0, 7) == 0) stream.push_back(sb.cmt);
      ncell = $urandom_range(1, 4);
      for (int k = 0; k < ncell; k++) begin
         if (k != 0) stream.push_back(sb.sep);
         case ($urandom_range(0, 9))
            0: ;
            1: if (sb.quo != 0) begin
               stream.push_back(sb.quo);
               push_plain($urandom_range(0, 3));
               stream.push_back(sb.quo);
               stream.push_back(sb.quo);
               push_plain($urandom_range(0, 3));
               stream.push_back(sb.quo);
            end
            2: if (sb.esc != 0) begin
               push_plain(1);
               stream.push_back(sb.esc);
               stream.push_back(8'($urandom_range(1, 255)));
            end
            3: begin
               stream.push_back(CH_SP);
               push_plain($urandom_range(1, 4));
               stream.push_back(CH_TAB);
            end
            4: push_plain($urandom_range(0, 4) == 0 ? $urandom_range(60, 75) : 8);
            default: push_plain($urandom_range(1, 6));
         endcase
      end
      if ($urandom_range(0, 1)) stream.push_back(CH_CR);
      stream.push_back(CH_LF);
      if ($urandom_range(0, 5) == 0) stream.push_back(CH_LF);
   endfunction

   function automatic void push_random(int nbytes);
      while (stream.size() < nbytes) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 5)) stream.push_back(8'($urandom_range(0, 255)));
         else
            push_row();
      end
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // skip count only loads on the first beat after reset
      csr_write(CSR_SKIP, 16'd2);
      csr_write(CSR_COMMENT, 16'("#"));
      csr_write(CSR_ESC, 16'("\\"));
      csr_write(CSR_FLAGS, 16'h7);
      push_text("s1\r\ns2\n#c,d\n a ,\"q\"\"x\",\\,z\n\n,\n");
      stream.push_back(8'h00);
      stream.push_back("\\");
      stream.push_back(8'h00);
      push_text("\n\tp\t,");
      stream.push_back(8'hFF);
      stream.push_back(8'h80);
      push_text("\n");
      drive_stream();
      settle();

      csr_write(CSR_SKIP, 16'hFFFF);
      csr_write(CSR_UNUSED, 16'hFFFF);
      csr_write(CSR_FLAGS, 16'h2);
      csr_write(CSR_ESC, 16'h00);
      push_random(15);
      drive_stream();
      settle();

      // zero separator and an 0xFF quote byte
      csr_write(CSR_SEP, 16'h00);
      csr_write(CSR_QUOTE, 16'hFF);
      csr_write(CSR_ESC, 16'h7C);
      csr_write(CSR_COMMENT, 16'h00);
      csr_write(CSR_FLAGS, 16'h3);
      push_text("a\n");
      stream.push_back(8'hFF);
      push_text("x");
      stream.push_back(8'hFF);
      stream.push_back(8'hFF);
      stream.push_back(8'h00);
      push_text("b\n");
      push_random(20);
      drive_stream();
      settle();

      csr_write(CSR_SEP, 16'hFF);
      csr_write(CSR_QUOTE, 16'h00);
      csr_write(CSR_ESC, 16'h00);
      csr_write(CSR_COMMENT, 16'hFE);
      csr_write(CSR_FLAGS, 16'h5);
      csr_write(CSR_SKIP, 16'h0);
      push_random(15);
      drive_stream();
      settle();

      csr_write(CSR_SEP, 16'(";"));
      csr_write(CSR_QUOTE, 16'("'"));
      csr_write(CSR_ESC, 16'("\\"));
      csr_write(CSR_COMMENT, 16'("#"));
      csr_write(CSR_FLAGS, 16'h1);
      push_random(15);
      drive_stream();
      settle();

      // fatal bad record, then everything after it is swallowed
      csr_write(CSR_FLAGS, 16'hF);
      push_text("a;b\n");
      stream.push_back(8'h00);
      push_text("x;y\nz\n");
      drive_stream();
      settle();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("*** PASSED ***");
      else begin
         if (sb.pending.size() != 0)
            $display("%0t: %0d expected beats never arrived, next %p",
                     $time, sb.pending.size(), sb.pending[0]);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/csvp_pkg.sv
src/csvp_ram.sv
src/csvp_front.sv
src/csvp_queue.sv
src/csvp_back.sv
src/delimited_text_cell_parser.sv
dv/tb_delimited_text_cell_parser.sv
